### hdl/psde_pkg.sv
// Shared widths, register codes and stage types of the partial-shell density pipeline.
// No dependencies; imported by psde_isqrt, psde_div, the top level and the testbench.
`default_nettype none

package psde_pkg;

  localparam int unsigned VEL_W         = 32;
  localparam int unsigned RAD_W         = 64;
  localparam int unsigned ROOT_W        = 32;
  localparam int unsigned QUO_W         = 31;
  localparam int unsigned DIV_REM_W     = 33;
  localparam int unsigned DEN_W         = 32;
  localparam int unsigned TAYLOR_TERMS  = 16;
  localparam int unsigned EXP_SQUARINGS = 5;
  localparam int unsigned CFG_IDX_W     = 3;

  // round(2^32 / (2*pi))
  localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHELL_SPEED = 3'd0,
    CFG_PITCH_EXP   = 3'd1,
    CFG_INV_SPEED   = 3'd2,
    CFG_INV_PITCH   = 3'd3,
    CFG_INV_DENOM   = 3'd4
  } cfg_reg_e;

  // One step of the exp(-r) series
  typedef struct packed {
    logic               far;
    logic [30:0]        r;
    logic [31:0]        term;
    logic signed [34:0] sum;
  } tay_stage_t;

endpackage

`default_nettype wire

### hdl/psde_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on psde_pkg for the radicand and root widths.
`default_nettype none

module psde_isqrt
  import psde_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o
);

  localparam int unsigned TW = RAD_W + 2;

  logic [RAD_W-1:0]  rem  [0:ROOT_W];
  logic [ROOT_W-1:0] root [0:ROOT_W];

  assign rem[0]  = rad_i;
  assign root[0] = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int unsigned B = ROOT_W - 1 - k;
    logic [TW-1:0]     trial;
    logic [RAD_W-1:0]  rem_q;
    logic [ROOT_W-1:0] root_q;

    // (root + 2^B)^2 - root^2
    assign trial = (TW'(root[k]) << (B + 1)) + (TW'(1) << (2 * B));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (TW'(rem[k]) >= trial) begin
          rem_q  <= rem[k] - trial[RAD_W-1:0];
          root_q <= root[k] | (ROOT_W'(1) << B);
        end else begin
          rem_q  <= rem[k];
          root_q <= root[k];
        end
      end
    end

    assign rem[k+1]  = rem_q;
    assign root[k+1] = root_q;
  end

  assign root_o = root[ROOT_W];

endmodule

`default_nettype wire

### hdl/psde_div.sv
// Pipelined restoring divider for the sine ratio p * 2^30 / x, one quotient bit a stage.
// Depends on psde_pkg; expects num_i <= den_i and carries a one-bit tag alongside.
`default_nettype none

module psde_div
  import psde_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [DEN_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic             tag_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             tag_o
);

  logic [DIV_REM_W-1:0] rem [0:QUO_W];
  logic [QUO_W-1:0]     quo [0:QUO_W];
  logic [DEN_W-1:0]     den [0:QUO_W];
  logic                 tag [0:QUO_W];

  assign rem[0] = DIV_REM_W'(num_i);
  assign quo[0] = '0;
  assign den[0] = den_i;
  assign tag[0] = tag_i;

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    localparam int unsigned B = QUO_W - 1 - k;
    logic                 ge;
    logic [DIV_REM_W-1:0] diff;
    logic [DIV_REM_W-1:0] rem_q;
    logic [QUO_W-1:0]     quo_q;
    logic [DEN_W-1:0]     den_q;
    logic                 tag_q;

    assign ge   = rem[k] >= DIV_REM_W'(den[k]);
    assign diff = ge ? rem[k] - DIV_REM_W'(den[k]) : rem[k];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= {diff[DIV_REM_W-2:0], 1'b0};
        quo_q <= ge ? (quo[k] | (QUO_W'(1) << B)) : quo[k];
        den_q <= den[k];
        tag_q <= tag[k];
      end
    end

    assign rem[k+1] = rem_q;
    assign quo[k+1] = quo_q;
    assign den[k+1] = den_q;
    assign tag[k+1] = tag_q;
  end

  assign quo_o = quo[QUO_W];
  assign tag_o = tag[QUO_W];

endmodule

`default_nettype wire

### hdl/partial_shell_density_eval_top.sv
// Partial-shell phase-space density evaluator: one request in, one density out.
// Depends on psde_pkg, psde_isqrt and psde_div.
//
// Slave stream: s_axis_tdata carries three signed Q5.26 velocity components.
// Master stream: m_axis_tdata carries the Q16.16 density, m_axis_tuser two flags.
// Configuration: a plain write port (cfg_we_i, cfg_idx_i, cfg_data_i); write it
// only while no request is in flight. Unknown indexes are ignored.
//
// With the default parameters the longest path is the pitch branch: a 31-stage
// divider followed by one multiply stage per power up to the largest exponent.
// Throughput is one request per cycle while the output is not stalled.
//
// Every stage advances together: when the output register holds a result the
// receiver does not take, the whole pipeline holds and s_axis_tready drops in
// the same cycle; nothing is lost or repeated. Reset clears all valid bits and
// restores the registers to their defaults (unit scale factors, zero shell speed,
// zero exponent).
`default_nettype none

module partial_shell_density_eval_top
  import psde_pkg::*;
#(
  parameter int unsigned VEL_FRAC_BITS      = 26,
  parameter int unsigned MAX_PITCH_EXPONENT = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [31:0] vel_parallel, [63:32] vel_perp_one, [95:64] vel_perp_two
  input  logic [3*VEL_W-1:0]   s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [31:0] density
  output logic [31:0]          m_axis_tdata,
  // [0] saturated, [1] zero_speed
  output logic [1:0]           m_axis_tuser,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int unsigned POW_STAGES = (MAX_PITCH_EXPONENT < 31) ? MAX_PITCH_EXPONENT : 31;
  localparam int unsigned LAT_V  = 2 + (2 * TAYLOR_TERMS - 1) + 1 + EXP_SQUARINGS;
  localparam int unsigned LAT_A  = QUO_W + POW_STAGES;
  localparam int unsigned LAT_BR = (LAT_V > LAT_A) ? LAT_V : LAT_A;
  localparam int unsigned DLY_V  = LAT_BR - LAT_V;
  localparam int unsigned DLY_A  = LAT_BR - LAT_A;
  localparam int unsigned LAT    = 2 + ROOT_W + LAT_BR + 6;
  localparam int unsigned SH_L   = (VEL_FRAC_BITS < 28) ? 28 - VEL_FRAC_BITS : 0;
  localparam int unsigned SH_R   = (VEL_FRAC_BITS > 28) ? VEL_FRAC_BITS - 28 : 0;
  localparam logic [63:0] FAR_LIM = 64'd5 << VEL_FRAC_BITS;

  // ---------------- configuration ----------------
  logic [30:0] shell_q;
  logic [4:0]  zeta_q;
  logic [31:0] isn_q, ipn_q, iden_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shell_q <= '0;
      zeta_q  <= '0;
      isn_q   <= 32'd16777216;
      ipn_q   <= 32'd16777216;
      iden_q  <= 32'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_SHELL_SPEED: shell_q <= cfg_data_i[30:0];
        CFG_PITCH_EXP:   zeta_q  <= cfg_data_i[4:0];
        CFG_INV_SPEED:   isn_q   <= cfg_data_i;
        CFG_INV_PITCH:   ipn_q   <= cfg_data_i;
        CFG_INV_DENOM:   iden_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [5:0] zeta_eff;
  assign zeta_eff = ({1'b0, zeta_q} > 6'(POW_STAGES)) ? 6'(POW_STAGES) : {1'b0, zeta_q};

  // ---------------- flow control ----------------
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // ---------------- squares and sums ----------------
  logic [VEL_W-1:0] vin [0:2];
  logic [VEL_W-1:0] mag [0:2];
  logic [63:0]      sq_q [0:2];
  logic [63:0]      s2_q, p2_q;

  for (genvar j = 0; j < 3; j++) begin : g_mag
    assign vin[j] = s_axis_tdata[j*VEL_W +: VEL_W];
    assign mag[j] = vin[j][VEL_W-1] ? (~vin[j] + VEL_W'(1)) : vin[j];
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[j] <= 64'(mag[j]) * 64'(mag[j]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_q <= sq_q[1] + sq_q[2];
      s2_q <= sq_q[0] + sq_q[1] + sq_q[2];
    end
  end

  logic [ROOT_W-1:0] x_w, p_w;

  psde_isqrt u_sqrt_x (.clk_i(clk_i), .en_i(en), .rad_i(s2_q), .root_o(x_w));
  psde_isqrt u_sqrt_p (.clk_i(clk_i), .en_i(en), .rad_i(p2_q), .root_o(p_w));

  // ---------------- speed branch: exp(-(x - xs)^2) ----------------
  logic [31:0] at;
  logic        far;
  logic [63:0] at_sh;
  logic [30:0] at28_q;
  logic        far_v1_q;

  assign at    = (x_w >= 32'(shell_q)) ? x_w - 32'(shell_q) : 32'(shell_q) - x_w;
  assign far   = 64'(at) >= FAR_LIM;
  assign at_sh = (64'(at) << SH_L) >> SH_R;

  always_ff @(posedge clk_i) begin
    if (en) begin
      at28_q   <= far ? '0 : at_sh[30:0];
      far_v1_q <= far;
    end
  end

  logic [63:0] usq;
  tay_stage_t  v2_q;
  tay_stage_t  tay [0:2*TAYLOR_TERMS];

  assign usq = 64'(at28_q) * 64'(at28_q) + 64'h8000_0000;

  always_ff @(posedge clk_i) begin
    if (en) begin
      v2_q.far  <= far_v1_q;
      v2_q.r    <= {usq[60:32], 2'b00};
      v2_q.term <= 32'h8000_0000;
      v2_q.sum  <= 35'sh0_8000_0000;
    end
  end

  assign tay[0] = v2_q;

  for (genvar n = 1; n <= TAYLOR_TERMS; n++) begin : g_tay
    localparam int unsigned N = n;
    localparam logic [35:0] RECIP = 36'(((64'd1 << 36) + N - 1) / N);
    tay_stage_t mul_q;
    logic [62:0] prod_a;

    // next term numerator; fold the previous term into the sum meanwhile
    assign prod_a = 63'(tay[2*n-2].term) * 63'(tay[2*n-2].r);

    always_ff @(posedge clk_i) begin
      if (en) begin
        mul_q.far  <= tay[2*n-2].far;
        mul_q.r    <= tay[2*n-2].r;
        mul_q.term <= {1'b0, prod_a[61:31]};
        if (N == 1) begin
          mul_q.sum <= tay[2*n-2].sum;
        end else if (((N - 1) % 2) == 1) begin
          mul_q.sum <= tay[2*n-2].sum - $signed({3'b000, tay[2*n-2].term});
        end else begin
          mul_q.sum <= tay[2*n-2].sum + $signed({3'b000, tay[2*n-2].term});
        end
      end
    end

    assign tay[2*n-1] = mul_q;

    if (N == 1) begin : g_pass
      assign tay[2*n] = mul_q;
    end else begin : g_recip
      tay_stage_t  div_q;
      logic [66:0] prod_b;
      // exact floor(q / N) by reciprocal, q below 2^31
      assign prod_b = 67'(mul_q.term[30:0]) * 67'(RECIP);
      always_ff @(posedge clk_i) begin
        if (en) begin
          div_q.far  <= mul_q.far;
          div_q.r    <= mul_q.r;
          div_q.term <= {1'b0, prod_b[66:36]};
          div_q.sum  <= mul_q.sum;
        end
      end
      assign tay[2*n] = div_q;
    end
  end

  logic signed [34:0] sum_f;
  logic [31:0]        y_c [0:EXP_SQUARINGS];
  logic               far_c [0:EXP_SQUARINGS];
  logic [31:0]        y0_q;
  logic               far0_q;

  assign sum_f = tay[2*TAYLOR_TERMS].sum + $signed({3'b000, tay[2*TAYLOR_TERMS].term});

  always_ff @(posedge clk_i) begin
    if (en) begin
      far0_q <= tay[2*TAYLOR_TERMS].far;
      priority if (sum_f[34]) begin
        y0_q <= '0;
      end else if (sum_f > 35'sh0_8000_0000) begin
        y0_q <= 32'h8000_0000;
      end else begin
        y0_q <= sum_f[31:0];
      end
    end
  end

  assign y_c[0]   = y0_q;
  assign far_c[0] = far0_q;

  for (genvar k = 0; k < EXP_SQUARINGS; k++) begin : g_sqr
    logic [63:0] ysq;
    logic [31:0] y_q;
    logic        f_q;
    assign ysq = 64'(y_c[k]) * 64'(y_c[k]) + 64'h4000_0000;
    always_ff @(posedge clk_i) begin
      if (en) begin
        y_q <= ysq[62:31];
        f_q <= far_c[k];
      end
    end
    assign y_c[k+1]   = y_q;
    assign far_c[k+1] = f_q;
  end

  logic [32:0] y_rnd;
  logic [24:0] fv, fv_al;

  assign y_rnd = {1'b0, y_c[EXP_SQUARINGS]} + 33'd64;
  assign fv    = far_c[EXP_SQUARINGS] ? '0 : y_rnd[31:7];

  if (DLY_V == 0) begin : g_nodly_v
    assign fv_al = fv;
  end else begin : g_dly_v
    logic [24:0] d_q [0:DLY_V-1];
    always_ff @(posedge clk_i) begin
      if (en) begin
        d_q[0] <= fv;
        for (int i = 1; i < DLY_V; i++) begin
          d_q[i] <= d_q[i-1];
        end
      end
    end
    assign fv_al = d_q[DLY_V-1];
  end

  // ---------------- pitch branch: (p / x)^zeta ----------------
  logic [QUO_W-1:0] s_w;
  logic             xz_w;

  psde_div u_div (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (p_w),
    .den_i (x_w),
    .tag_i (x_w == '0),
    .quo_o (s_w),
    .tag_o (xz_w)
  );

  logic [30:0] pw_c [0:POW_STAGES];
  logic [30:0] sc_c [0:POW_STAGES];
  logic        xz_c [0:POW_STAGES];

  assign pw_c[0] = 31'h4000_0000;
  assign sc_c[0] = (s_w > 31'h4000_0000) ? 31'h4000_0000 : s_w;
  assign xz_c[0] = xz_w;

  for (genvar i = 1; i <= POW_STAGES; i++) begin : g_pow
    localparam int unsigned I = i;
    logic [61:0] pprod;
    logic [30:0] pw_q, sc_q;
    logic        xz_q;
    assign pprod = 62'(pw_c[i-1]) * 62'(sc_c[i-1]) + 62'h2000_0000;
    always_ff @(posedge clk_i) begin
      if (en) begin
        pw_q <= (6'(I) <= zeta_eff) ? pprod[60:30] : pw_c[i-1];
        sc_q <= sc_c[i-1];
        xz_q <= xz_c[i-1];
      end
    end
    assign pw_c[i] = pw_q;
    assign sc_c[i] = sc_q;
    assign xz_c[i] = xz_q;
  end

  logic [30:0] pw_rnd;
  logic [24:0] fa;
  logic        zf;
  logic [25:0] fa_al;

  assign pw_rnd = pw_c[POW_STAGES] + 31'd32;
  assign zf     = xz_c[POW_STAGES] && (zeta_q != '0);
  always_comb begin
    priority if (zeta_q == '0) begin
      fa = 25'd16777216;
    end else if (xz_c[POW_STAGES]) begin
      fa = '0;
    end else begin
      fa = pw_rnd[30:6];
    end
  end

  if (DLY_A == 0) begin : g_nodly_a
    assign fa_al = {zf, fa};
  end else begin : g_dly_a
    logic [25:0] d_q [0:DLY_A-1];
    always_ff @(posedge clk_i) begin
      if (en) begin
        d_q[0] <= {zf, fa};
        for (int i = 1; i < DLY_A; i++) begin
          d_q[i] <= d_q[i-1];
        end
      end
    end
    assign fa_al = d_q[DLY_A-1];
  end

  // ---------------- product chain ----------------
  logic [56:0] pa, pb;
  logic [32:0] a_q, b_q;
  logic [65:0] pc;
  logic [41:0] c_q;
  logic [61:0] pl3_q;
  logic [39:0] ph3_q;
  logic [71:0] d_sum;
  logic [39:0] d_q;
  logic [63:0] pl4_q;
  logic [39:0] ph4_q;
  logic [71:0] e_sum;
  logic [47:0] e;
  logic        zf_q [0:4];
  logic [31:0] dens_q;
  logic        sat_q, zs_q;

  assign pa = 57'(fv_al) * 57'(isn_q) + 57'h80_0000;
  assign pb = 57'(fa_al[24:0]) * 57'(ipn_q) + 57'h80_0000;
  assign pc = 66'(a_q) * 66'(b_q) + 66'h80_0000;

  assign d_sum = 72'(pl3_q) + (72'(ph3_q) << 32) + 72'h8000_0000;
  assign e_sum = 72'(pl4_q) + (72'(ph4_q) << 32) + 72'h80_0000;
  assign e     = e_sum[71:24];

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q     <= pa[56:24];
      b_q     <= pb[56:24];
      zf_q[0] <= fa_al[25];
      c_q     <= pc[65:24];
      zf_q[1] <= zf_q[0];
      pl3_q   <= 62'(c_q[31:0]) * 62'(INV_TWO_PI_Q32);
      ph3_q   <= 40'(c_q[41:32]) * 40'(INV_TWO_PI_Q32);
      zf_q[2] <= zf_q[1];
      d_q     <= d_sum[71:32];
      zf_q[3] <= zf_q[2];
      pl4_q   <= 64'(d_q[31:0]) * 64'(iden_q);
      ph4_q   <= 40'(d_q[39:32]) * 40'(iden_q);
      zf_q[4] <= zf_q[3];
      // clamp anything above 32 bits
      sat_q   <= |e[47:32];
      dens_q  <= (|e[47:32]) ? '1 : e[31:0];
      zs_q    <= zf_q[4];
    end
  end

  assign m_axis_tdata = dens_q;
  assign m_axis_tuser = {zs_q, sat_q};

endmodule

`default_nettype wire

### hdl/psde_checker.sv
// Port-level checks of the partial-shell density evaluator, bound to its top level.
// Depends on partial_shell_density_eval_top for the bind target.
`default_nettype none

module psde_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // input side only backs up when the output is blocked
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 32'hFFFF_FFFF)
    else $error("saturated flag without clamped density");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == 32'h0 && !m_axis_tuser[0])
    else $error("zero speed with nonzero density");

endmodule

bind partial_shell_density_eval_top psde_checker u_psde_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

### tb/tb_partial_shell_density_eval_top.sv
// Testbench for partial_shell_density_eval_top: directed table plus random velocities,
// checked against a fixed-point density predictor. Depends on psde_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_partial_shell_density_eval_top;
  import psde_pkg::*;

  localparam int unsigned FRAC = 26;
  localparam int unsigned LATENCY = 102;
  localparam longint unsigned ONE24 = 64'd1 << 24;
  localparam longint unsigned ONE30 = 64'd1 << 30;
  localparam longint unsigned ONE31 = 64'd1 << 31;
  localparam longint unsigned K2PI = 64'd683565276;
  localparam logic [31:0] NO_CHECK = 32'hDEAD_BEEF;

  typedef struct packed {
    logic [31:0] density;
    logic        saturated;
    logic        zero_speed;
  } density_t;

  typedef struct {
    logic [31:0] v0, v1, v2;
    logic        fixed;
    logic [31:0] density;
    logic        saturated, zero_speed;
  } vel_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  logic [30:0] shell_speed;
  logic [4:0] pitch_exp;
  logic [31:0] inv_speed, inv_pitch, inv_denom;

  density_t expected_q[$];
  int errors = 0;
  bit hold_off = 1'b0;
  bit send_done = 1'b0;

  partial_shell_density_eval_top i_dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // round(a*b/2^sh), clamp to all ones
  function automatic longint unsigned mul_round(longint unsigned a, longint unsigned b,
                                                int sh);
    logic [128:0] prod;
    prod = (129'(a) * 129'(b) + (129'(1) << (sh - 1))) >> sh;
    if (prod[128:64] != 0) return 64'hFFFF_FFFF_FFFF_FFFF;
    return prod[63:0];
  endfunction

  function automatic longint unsigned gauss_q24(longint unsigned u);
    longint unsigned r, term, y;
    longint signed acc;
    r = u << 2;
    term = ONE31;
    acc = ONE31;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * r) >> 31) / n;
      if (n % 2) acc -= term;
      else acc += term;
    end
    if (acc < 0) acc = 0;
    y = acc;
    if (y > ONE31) y = ONE31;
    for (int i = 0; i < 5; i++) y = (y * y + (64'd1 << 30)) >> 31;
    return (y + 64) >> 7;
  endfunction

  function automatic longint unsigned mag(logic [31:0] v);
    return v[31] ? longint'(32'(-v)) : longint'(v);
  endfunction

  function automatic density_t predict_density(logic [31:0] v0, v1, v2);
    density_t res;
    longint unsigned m0, m1, m2, p2, x, p, at, fv, fa, s, pw, a, b, c, d, e, at28;
    m0 = mag(v0);
    m1 = mag(v1);
    m2 = mag(v2);
    p2 = m1 * m1 + m2 * m2;
    x = sqrt_floor(p2 + m0 * m0);
    p = sqrt_floor(p2);
    at = (x >= shell_speed) ? x - shell_speed : shell_speed - x;
    res = '0;
    if (at >= (64'd5 << FRAC)) fv = 0;
    else begin
      at28 = at << (28 - FRAC);
      fv = gauss_q24((at28 * at28 + (64'd1 << 31)) >> 32);
    end
    if (pitch_exp == 0) fa = ONE24;
    else if (x == 0) begin
      fa = 0;
      res.zero_speed = 1'b1;
    end else begin
      s = (p << 30) / x;
      if (s > ONE30) s = ONE30;
      pw = ONE30;
      for (int i = 0; i < pitch_exp; i++) pw = (pw * s + (64'd1 << 29)) >> 30;
      fa = (pw + 32) >> 6;
    end
    a = mul_round(fv, inv_speed, 24);
    b = mul_round(fa, inv_pitch, 24);
    c = mul_round(a, b, 24);
    d = mul_round(c, K2PI, 32);
    e = mul_round(d, inv_denom, 24);
    if (e > 64'hFFFF_FFFF) begin
      e = 64'hFFFF_FFFF;
      res.saturated = 1'b1;
    end
    res.density = e[31:0];
    return res;
  endfunction

  // one write, then write enable dropped before returning, so back-to-back writes never collide
  task automatic write_reg(cfg_reg_e idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SHELL_SPEED: shell_speed = val[30:0];
      CFG_PITCH_EXP:   pitch_exp = val[4:0];
      CFG_INV_SPEED:   inv_speed = val;
      CFG_INV_PITCH:   inv_pitch = val;
      CFG_INV_DENOM:   inv_denom = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain_pipe();
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  // Push one request; hold valid across back-to-back items
  task automatic send_vel(logic [31:0] v0, v1, v2, density_t exp_res, bit typed);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {v2, v1, v0};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_q.push_back(typed ? exp_res : predict_density(v0, v1, v2));
  endtask

  task automatic random_vel(output logic [31:0] v0, v1, v2);
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) begin
      // around half the shell speed on the parallel axis, small on the others
      v0 = $urandom_range(0, 32'h0FFF_FFFF) - 32'h07FF_FFFF + shell_speed / 2;
      v1 = $urandom_range(0, 32'h0FFF_FFFF) - 32'h07FF_FFFF;
      v2 = $urandom_range(0, 32'h0FFF_FFFF) - 32'h07FF_FFFF;
    end else if (k < 9) begin
      v0 = $urandom;
      v1 = $urandom;
      v2 = $urandom;
    end else begin
      v0 = '0;
      v1 = ($urandom_range(0, 1)) ? '0 : $urandom;
      v2 = '0;
    end
  endtask

  initial begin
    vel_row_t rows[$];
    density_t tr;
    logic [31:0] v0, v1, v2;
    shell_speed = '0;
    pitch_exp = '0;
    inv_speed = 32'd16777216;
    inv_pitch = 32'd16777216;
    inv_denom = 32'd65536;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: zero velocity, unit scales -> exp(0)*K scaled to Q16
    rows.push_back('{32'd0, 32'd0, 32'd0, 1'b1, 32'd10430, 1'b0, 1'b0});
    rows.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'd0, 1'b0, 1'b0});
    rows.push_back('{32'h7FFF_FFFF, 32'd0, 32'd0, 1'b1, 32'd0, 1'b0, 1'b0});
    rows.push_back('{32'h0400_0000, 32'd0, 32'd0, 1'b0, NO_CHECK, 1'b0, 1'b0});
    rows.push_back('{32'hFC00_0000, 32'h0400_0000, 32'hFC00_0000, 1'b0, NO_CHECK, 1'b0, 1'b0});
    rows.push_back('{32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 1'b0, NO_CHECK, 1'b0, 1'b0});
    foreach (rows[i]) begin
      tr = '{rows[i].density, rows[i].saturated, rows[i].zero_speed};
      send_vel(rows[i].v0, rows[i].v1, rows[i].v2, tr, rows[i].fixed);
    end
    s_axis_tvalid <= 1'b0;
    drain_pipe();

    // zero speed with exponent, maximum exponent
    write_reg(CFG_PITCH_EXP, 32'd31);
    rows.delete();
    rows.push_back('{32'd0, 32'd0, 32'd0, 1'b1, 32'd0, 1'b0, 1'b1});
    rows.push_back('{32'd0, 32'h0400_0000, 32'd0, 1'b0, NO_CHECK, 1'b0, 1'b0});
    rows.push_back('{32'h0100_0000, 32'h0300_0000, 32'hFD00_0000, 1'b0, NO_CHECK, 1'b0, 1'b0});
    rows.push_back('{32'h0400_0000, 32'd0, 32'd0, 1'b0, NO_CHECK, 1'b0, 1'b0});
    foreach (rows[i]) begin
      tr = '{rows[i].density, rows[i].saturated, rows[i].zero_speed};
      send_vel(rows[i].v0, rows[i].v1, rows[i].v2, tr, rows[i].fixed);
    end
    s_axis_tvalid <= 1'b0;
    drain_pipe();

    // huge scales saturate; unknown index ignored
    write_reg(CFG_PITCH_EXP, 32'd0);
    write_reg(CFG_INV_SPEED, 32'hFFFF_FFFF);
    write_reg(CFG_INV_PITCH, 32'hFFFF_FFFF);
    write_reg(CFG_INV_DENOM, 32'hFFFF_FFFF);
    write_reg(CFG_SHELL_SPEED, 32'hFFFF_FFFF);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= 3'd7;
    cfg_data_i <= 32'h0;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    send_vel(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, 1'b0);
    s_axis_tvalid <= 1'b0;
    drain_pipe();
    write_reg(CFG_SHELL_SPEED, 32'h0800_0000);
    send_vel(32'h0800_0000, 32'd0, 32'd0, '{32'hFFFF_FFFF, 1'b1, 1'b0}, 1'b1);
    s_axis_tvalid <= 1'b0;
    drain_pipe();

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_SHELL_SPEED, (ph == 4) ? 32'h7FFF_FFFF : $urandom_range(0, 32'h1000_0000));
      write_reg(CFG_PITCH_EXP, (ph == 0) ? 32'd0 : (ph == 1) ? 32'd31 : $urandom_range(0, 31));
      write_reg(CFG_INV_SPEED, (ph == 0) ? 32'd0 : $urandom);
      write_reg(CFG_INV_PITCH, (ph == 1) ? 32'hFFFF_FFFF : $urandom);
      write_reg(CFG_INV_DENOM, (ph == 2) ? 32'd0 : $urandom_range(0, 32'h0100_0000));
      if (ph == 2) hold_off = 1'b1;
      for (int n = 0; n < 200; n++) begin
        random_vel(v0, v1, v2);
        send_vel(v0, v1, v2, '0, 1'b0);
      end
      s_axis_tvalid <= 1'b0;
      drain_pipe();
    end
    send_done = 1'b1;
  end

  // receiver with random stalls and one long hold-off
  initial begin
    int stall;
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      stall = $urandom_range(0, 11);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    density_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected density result %h", m_axis_tdata);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (m_axis_tdata !== want.density) begin
          $error("density: expected %h, got %h", want.density, m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser[0] !== want.saturated) begin
          $error("saturated: expected %b, got %b", want.saturated, m_axis_tuser[0]);
          errors++;
        end
        if (m_axis_tuser[1] !== want.zero_speed) begin
          $error("zero_speed: expected %b, got %b", want.zero_speed, m_axis_tuser[1]);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (send_done);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb_partial_shell_density_eval_top: done, clean");
    end else begin
      $display("tb_partial_shell_density_eval_top: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_partial_shell_density_eval_top: done, errors");
    $finish;
  end

endmodule
